// File: sv/cds_pkg.sv
// shared types, character codes and defaults for the declaration splitter
`default_nettype none

package cds_pkg;

   localparam int TEXT_BYTES_DEF  = 65536;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int POS_W = 16;
   localparam int CNT_W = 8;

   localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 8'd16;

   // character codes
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_COLON  = 8'h3a;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_L      = 8'h6c;
   localparam logic [7:0] CH_NUL    = 8'h00;

   typedef enum logic [1:0] {
      PH_PROP_BEGIN,
      PH_PROP_END,
      PH_VAL_BEGIN,
      PH_VALUE
   } phase_type;

   // one classified input byte
   typedef struct packed {
      logic       last;
      logic       is_zero;
      logic       is_ws;
      logic       is_colon;
      logic       is_semi;
      logic       is_rparen;
      logic       is_u;
      logic [3:1] url_hit;   // bit n set when the byte matches char n+1 of "url("
   } cls_type;

   typedef struct packed {
      logic             has_property;
      logic [POS_W-1:0] property_start;
      logic [POS_W-1:0] property_length;
      logic             has_value;
      logic [POS_W-1:0] value_start;
      logic [POS_W-1:0] value_length;
      logic [CNT_W-1:0] entry_count;
   } decl_type;

   // records produced by one byte: optional declaration, optional done
   typedef struct packed {
      logic             decl_valid;
      decl_type         decl;
      logic             done_valid;
      logic [CNT_W-1:0] done_count;
   } bundle_type;

endpackage

`default_nettype wire

// File: sv/css_declaration_splitter.sv
// top level of the style declaration splitter
//
//  channel  direction  handshake                    payload
//  req      in         req_tvalid / req_tready      tdata[7:0] text_byte, tlast end_of_text
//  rsp      out        rsp_tvalid / rsp_tready      tdata spans and count, tuser flags,
//                                                   tlast done_res
//  csr      in         csr_valid / csr_ready        csr_data max_entries
//
// one byte per cycle while records are taken: the front classifies a byte in its
// accept cycle and the back applies the whole phase update when it pops it, so
// bytes stream back to back; for a byte that yields a declaration and the done
// record the response register holds the pair while the queue keeps filling;
// a request reaches its first record through the queue and the response register
// synchronous active-high reset clears phase, counters and flags; max_entries
// returns to 16; no clearing pass is needed
// req_tready drops only when the queue is full; rsp stalls back up into it
`default_nettype none

module css_declaration_splitter
   import cds_pkg::*;
#(
   parameter int TEXT_BYTES  = TEXT_BYTES_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_text

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [15:0] property_start, [31:16] property_length,
                                    // [47:32] value_start, [63:48] value_length,
                                    // [71:64] entry_count
   output logic [1:0]  rsp_tuser,   // [0] has_property, [1] has_value
   output logic        rsp_tlast,   // done_res

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // max_entries
);

   logic [CNT_W-1:0] max_entries_ff;

   logic       push_valid, push_ready;
   cls_type    push_item;
   logic       q_valid, q_pop;
   cls_type    q_item;
   logic       out_can_load, out_load;
   bundle_type out_bundle;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= MAX_ENTRIES_RST;
      end else if (csr_valid) begin
         max_entries_ff <= csr_data;
      end
   end

   // byte classification at the request port
   cds_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .q_ready     (push_ready),
      .push_valid  (push_valid),
      .push_item   (push_item)
   );

   // decouples the request side from response stalls
   cds_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item)
   );

   // phase machine; bytes that emit nothing retire even while rsp is stalled
   cds_back #(
      .TEXT_BYTES (TEXT_BYTES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .max_entries  (max_entries_ff),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .out_can_load (out_can_load),
      .out_load     (out_load),
      .out_bundle   (out_bundle)
   );

   // response register, serializes declaration then done record
   cds_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .bundle     (out_bundle),
      .can_load   (out_can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: sv/cds_front.sv
// front end: takes bytes off the request stream and classifies them
`default_nettype none

module cds_front
   import cds_pkg::*;
(
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] text_byte,
   input  logic       end_of_text,
   input  logic       q_ready,
   output logic       push_valid,
   output cls_type    push_item
);

   always_comb begin
      push_item.last      = end_of_text;
      push_item.is_zero   = (text_byte == CH_NUL);
      push_item.is_ws     = (text_byte <= CH_SPACE);
      push_item.is_colon  = (text_byte == CH_COLON);
      push_item.is_semi   = (text_byte == CH_SEMI);
      push_item.is_rparen = (text_byte == CH_RPAREN);
      push_item.is_u      = (text_byte == CH_U);
      push_item.url_hit   = {text_byte == CH_LPAREN, text_byte == CH_L, text_byte == CH_R};
   end

   assign push_valid = req_tvalid;
   assign req_tready = q_ready;

endmodule

`default_nettype wire

// File: sv/cds_queue.sv
// short queue of classified bytes between front and back
`default_nettype none

module cds_queue
   import cds_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cls_type push_item,
   output logic    q_valid,
   input  logic    q_pop,
   output cls_type q_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int QC_W  = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [QC_W-1:0]  FULL_CNT = QC_W'(DEPTH);

   cls_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]  count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign q_valid    = (count_ff != '0);
   assign q_item     = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: sv/cds_back.sv
// back end: phase machine, span registers and record generation
`default_nettype none

module cds_back
   import cds_pkg::*;
#(
   parameter int TEXT_BYTES = TEXT_BYTES_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] max_entries,
   input  logic             q_valid,
   input  cls_type          q_item,
   output logic             q_pop,
   input  logic             out_can_load,
   output logic             out_load,
   output bundle_type       out_bundle
);

   localparam int POS_LIMIT_I = (TEXT_BYTES - 1 < 65535) ? TEXT_BYTES - 1 : 65535;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIMIT_I);

   function automatic logic [POS_W-1:0] span(input logic [POS_W-1:0] stop,
                                             input logic [POS_W-1:0] start);
      return (stop >= start) ? stop - start : '0;
   endfunction

   phase_type        phase_ff, phase_in, phase_mid;
   logic             paren_ff, paren_in, paren_mid;
   logic [1:0]       url_ff, url_in, url_mid;
   logic [POS_W-1:0] pos_ff, pos_in, pos_mid;
   logic [CNT_W-1:0] entries_ff, entries_in;
   logic [POS_W-1:0] ps_ff, ps_in, ps_mid;
   logic [POS_W-1:0] pl_ff, pl_in, pl_mid;
   logic [POS_W-1:0] vs_ff, vs_in, vs_mid;
   logic [POS_W-1:0] vl_ff, vl_in, vl_mid;
   logic [1:0]       pf_ff, pf_in, pf_mid;
   logic             finished_ff, finished_in;

   logic full, step, flush_end, skip_ws, hit, term_hit;
   logic rec_step, flush_decl, decl_valid, has_rec;

   // byte processing
   always_comb begin
      phase_mid = phase_ff;
      paren_mid = paren_ff;
      url_mid   = url_ff;
      pos_mid   = pos_ff;
      ps_mid    = ps_ff;
      pl_mid    = pl_ff;
      vs_mid    = vs_ff;
      vl_mid    = vl_ff;
      pf_mid    = pf_ff;
      skip_ws   = 1'b0;
      hit       = 1'b0;
      term_hit  = 1'b0;
      full      = (entries_ff >= max_entries);
      step      = !finished_ff && !full && !q_item.is_zero;
      flush_end = !finished_ff && (q_item.is_zero || q_item.last);
      if (step) begin
         // url( match runs on the first bytes of a value
         if (phase_ff == PH_VALUE && url_ff != 2'd0) begin
            case (url_ff)
               2'd1:    hit = q_item.url_hit[1];
               2'd2:    hit = q_item.url_hit[2];
               default: hit = q_item.url_hit[3];
            endcase
            if (hit) begin
               if (url_ff == 2'd3) begin
                  paren_mid = 1'b1;
                  url_mid   = 2'd0;
               end else begin
                  url_mid = url_ff + 2'd1;
               end
            end else begin
               url_mid = 2'd0;
            end
         end
         term_hit = paren_mid ? q_item.is_rparen : q_item.is_semi;
         if (q_item.is_ws) begin
            if (phase_ff == PH_PROP_BEGIN || phase_ff == PH_VAL_BEGIN) begin
               skip_ws = 1'b1;
            end else if (phase_ff == PH_PROP_END) begin
               pl_mid    = span(pos_ff, ps_ff);
               phase_mid = PH_VAL_BEGIN;
            end
         end else if (q_item.is_colon) begin
            if (phase_ff == PH_PROP_END) begin
               pl_mid    = span(pos_ff, ps_ff);
               phase_mid = PH_VAL_BEGIN;
               paren_mid = 1'b0;
            end
         end else if (term_hit) begin
            if (paren_mid) begin
               paren_mid = 1'b0;
            end else begin
               if (pf_ff[1]) begin
                  vl_mid = span(pos_ff, vs_ff);
               end
               phase_mid = PH_PROP_BEGIN;
               url_mid   = 2'd0;
            end
         end else if (phase_ff == PH_PROP_BEGIN) begin
            ps_mid    = pos_ff;
            pf_mid[0] = 1'b1;
            phase_mid = PH_PROP_END;
         end else if (phase_ff == PH_VAL_BEGIN) begin
            vs_mid    = pos_ff;
            pf_mid[1] = 1'b1;
            phase_mid = PH_VALUE;
            url_mid   = q_item.is_u ? 2'd1 : 2'd0;
         end
         if (pos_ff < POS_LIMIT) begin
            pos_mid = pos_ff + 1'b1;
         end
      end
      rec_step   = step && !skip_ws && (phase_mid == PH_PROP_BEGIN);
      flush_decl = flush_end && !full && (phase_mid == PH_VALUE);
      decl_valid = rec_step || flush_decl;
      has_rec    = decl_valid || flush_end;
   end

   // next state
   always_comb begin
      phase_in    = phase_mid;
      paren_in    = paren_mid;
      url_in      = url_mid;
      pos_in      = pos_mid;
      ps_in       = ps_mid;
      pl_in       = pl_mid;
      vs_in       = vs_mid;
      vl_in       = vl_mid;
      pf_in       = pf_mid;
      entries_in  = entries_ff;
      finished_in = finished_ff || flush_end;
      if (decl_valid) begin
         entries_in = entries_ff + 1'b1;
         ps_in      = '0;
         pl_in      = '0;
         vs_in      = '0;
         vl_in      = '0;
         pf_in      = 2'b00;
      end
      if (flush_decl) begin
         phase_in = PH_PROP_BEGIN;
      end
   end

   // outputs
   always_comb begin
      out_bundle.decl_valid           = decl_valid;
      out_bundle.decl.has_property    = pf_mid[0];
      out_bundle.decl.property_start  = ps_mid;
      out_bundle.decl.property_length = pl_mid;
      out_bundle.decl.has_value       = pf_mid[1];
      out_bundle.decl.value_start     = vs_mid;
      out_bundle.decl.value_length    = flush_decl ? span(pos_mid, vs_mid) : vl_mid;
      out_bundle.decl.entry_count     = entries_ff + 1'b1;
      out_bundle.done_valid           = flush_end;
      out_bundle.done_count           = entries_ff + CNT_W'(decl_valid);
      q_pop    = q_valid && (!has_rec || out_can_load);
      out_load = q_valid && has_rec && out_can_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_PROP_BEGIN;
         paren_ff    <= 1'b0;
         url_ff      <= 2'd0;
         pos_ff      <= '0;
         entries_ff  <= '0;
         ps_ff       <= '0;
         pl_ff       <= '0;
         vs_ff       <= '0;
         vl_ff       <= '0;
         pf_ff       <= 2'b00;
         finished_ff <= 1'b0;
      end else if (q_pop) begin
         phase_ff    <= phase_in;
         paren_ff    <= paren_in;
         url_ff      <= url_in;
         pos_ff      <= pos_in;
         entries_ff  <= entries_in;
         ps_ff       <= ps_in;
         pl_ff       <= pl_in;
         vs_ff       <= vs_in;
         vl_ff       <= vl_in;
         pf_ff       <= pf_in;
         finished_ff <= finished_in;
      end
   end

   a_finished_holds: assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("finished flag dropped without reset");

   a_no_record_after_done: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !out_load)
      else $error("record produced after done record");

   a_prop_end_has_start: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PROP_END) |-> pf_ff[0])
      else $error("property end phase without property start flag");

   a_value_has_start: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_VALUE) |-> pf_ff[1])
      else $error("value phase without value start flag");

   a_pos_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (pos_ff >= $past(pos_ff)) && (pos_ff <= POS_LIMIT))
      else $error("position went backward or past its limit");

endmodule

`default_nettype wire

// File: sv/cds_out.sv
// response register: presents the declaration record, then the done record
`default_nettype none

module cds_out
   import cds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  bundle_type        bundle,
   output logic              can_load,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [71:0]       rsp_tdata,
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);

   decl_type         decl_ff;
   logic [CNT_W-1:0] done_cnt_ff;
   logic             decl_pend_ff, decl_pend_in;
   logic             done_pend_ff, done_pend_in;
   logic             take;

   assign rsp_tvalid = decl_pend_ff || done_pend_ff;
   assign take       = rsp_tvalid && rsp_tready;
   assign can_load   = !rsp_tvalid || (take && !(decl_pend_ff && done_pend_ff));

   always_comb begin
      decl_pend_in = decl_pend_ff;
      done_pend_in = done_pend_ff;
      if (take) begin
         if (decl_pend_ff) begin
            decl_pend_in = 1'b0;
         end else begin
            done_pend_in = 1'b0;
         end
      end
      if (load) begin
         decl_pend_in = bundle.decl_valid;
         done_pend_in = bundle.done_valid;
      end
   end

   always_comb begin
      if (decl_pend_ff) begin
         rsp_tdata = {decl_ff.entry_count, decl_ff.value_length, decl_ff.value_start,
                      decl_ff.property_length, decl_ff.property_start};
         rsp_tuser = {decl_ff.has_value, decl_ff.has_property};
         rsp_tlast = 1'b0;
      end else begin
         rsp_tdata = {done_cnt_ff, 64'd0};
         rsp_tuser = 2'b00;
         rsp_tlast = done_pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decl_pend_ff <= 1'b0;
         done_pend_ff <= 1'b0;
      end else begin
         decl_pend_ff <= decl_pend_in;
         done_pend_ff <= done_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         decl_ff     <= bundle.decl;
         done_cnt_ff <= bundle.done_count;
      end
   end

endmodule

`default_nettype wire

// File: sim/css_declaration_splitter_tb.sv
// self-checking testbench for the style declaration splitter: stream stimulus, predictor, checker
`default_nettype none

module css_declaration_splitter_tb
   import cds_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // position saturates here, offsets and lengths never wrap past it
   localparam int POS_CAP       = (TEXT_BYTES_DEF - 1 < 65535) ? TEXT_BYTES_DEF - 1 : 65535;
   // queue plus response register, with some margin, before a csr write
   localparam int DRAIN_CYCLES  = 8;
   localparam int LONG_HOLD     = 400;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_BYTES  = 1300;
   localparam int LONG_RUN      = 200;
   localparam int ENTRY_CEILING = 240;

   // one record as it leaves the rsp channel
   typedef struct packed {
      logic             has_property;
      logic [POS_W-1:0] property_start;
      logic [POS_W-1:0] property_length;
      logic             has_value;
      logic [POS_W-1:0] value_start;
      logic [POS_W-1:0] value_length;
      logic [CNT_W-1:0] entry_count;
      logic             done_res;
   } decl_record_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = 8'd0;

   css_declaration_splitter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------------
   // predictor state, a private copy of what the splitter tracks
   // ---------------------------------------------------------------------------
   phase_type        phase_now     = PH_PROP_BEGIN;
   logic             paren_on      = 1'b0;   // ';' is ordinary until ')'
   logic [2:0]       url_seen      = 3'd0;   // bytes of "url(" matched so far
   logic [POS_W-1:0] text_pos      = '0;
   logic [CNT_W-1:0] decls_out     = '0;
   logic [CNT_W-1:0] entry_limit   = MAX_ENTRIES_RST;
   logic [POS_W-1:0] prop_start_q  = '0;
   logic [POS_W-1:0] prop_len_q    = '0;
   logic [POS_W-1:0] val_start_q   = '0;
   logic [POS_W-1:0] val_len_q     = '0;
   logic [1:0]       present_q     = 2'b00;  // [0] property seen, [1] value seen
   logic             text_done     = 1'b0;

   decl_record_type pending_declarations[$];
   int              bytes_processed = 0;   // bytes the splitter actually works on
   int              fail_count      = 0;
   int              cycle_count     = 0;

   // idling controls shared with the receiver
   bit sender_idle       = 1'b0;
   bit receiver_idle     = 1'b0;
   bit long_hold_request = 1'b0;

   function automatic logic [POS_W-1:0] span_len(input logic [POS_W-1:0] stop,
                                                 input logic [POS_W-1:0] start);
      return (stop >= start) ? stop - start : '0;
   endfunction

   // one nonzero byte through the phase machine; returns 1 when a record is due
   function automatic bit absorb_byte(input logic [7:0] c);
      logic [7:0] term;
      logic [7:0] want;
      bit         skipped;
      term = paren_on ? CH_RPAREN : CH_SEMI;
      // "url(" is matched one byte at a time, only from the first value byte on
      if (phase_now == PH_VALUE && url_seen >= 3'd1 && url_seen <= 3'd3) begin
         case (url_seen)
            3'd1:    want = CH_R;
            3'd2:    want = CH_L;
            default: want = CH_LPAREN;
         endcase
         if (c == want) begin
            url_seen = url_seen + 3'd1;
            if (url_seen == 3'd4) begin
               paren_on = 1'b1;
               url_seen = 3'd0;
            end
         end else begin
            url_seen = 3'd0;
         end
         term = paren_on ? CH_RPAREN : CH_SEMI;
      end
      skipped = (c <= CH_SPACE) && (phase_now == PH_PROP_BEGIN || phase_now == PH_VAL_BEGIN);
      if (c <= CH_SPACE) begin
         if (phase_now == PH_PROP_END) begin
            prop_len_q = span_len(text_pos, prop_start_q);
            phase_now  = PH_VAL_BEGIN;
         end
      end else if (c == CH_COLON) begin
         if (phase_now == PH_PROP_END) begin
            prop_len_q = span_len(text_pos, prop_start_q);
            phase_now  = PH_VAL_BEGIN;
            paren_on   = 1'b0;
         end
      end else if (c == term) begin
         if (paren_on) begin
            paren_on = 1'b0;
         end else begin
            if (present_q[1])
               val_len_q = span_len(text_pos, val_start_q);
            phase_now = PH_PROP_BEGIN;
            url_seen  = 3'd0;
         end
      end else if (phase_now == PH_PROP_BEGIN) begin
         prop_start_q = text_pos;
         present_q[0] = 1'b1;
         phase_now    = PH_PROP_END;
      end else if (phase_now == PH_VAL_BEGIN) begin
         val_start_q  = text_pos;
         present_q[1] = 1'b1;
         phase_now    = PH_VALUE;
         url_seen     = (c == CH_U) ? 3'd1 : 3'd0;
      end
      if (text_pos < POS_CAP)
         text_pos = text_pos + 1'b1;
      return !skipped && phase_now == PH_PROP_BEGIN;
   endfunction

   task automatic emit_declaration();
      decl_record_type rec;
      decls_out            = decls_out + 1'b1;
      rec.has_property     = present_q[0];
      rec.property_start   = prop_start_q;
      rec.property_length  = prop_len_q;
      rec.has_value        = present_q[1];
      rec.value_start      = val_start_q;
      rec.value_length     = val_len_q;
      rec.entry_count      = decls_out;
      rec.done_res         = 1'b0;
      pending_declarations.push_back(rec);
      prop_start_q = '0;
      prop_len_q   = '0;
      val_start_q  = '0;
      val_len_q    = '0;
      present_q    = 2'b00;
   endtask

   // expected records for one accepted transaction on the req channel
   task automatic split_text_byte(input logic [7:0] c, input logic last);
      decl_record_type rec;
      bit              full;
      if (text_done)
         return;
      full = decls_out >= entry_limit;
      if (!full)
         bytes_processed++;
      if (!full && c != CH_NUL) begin
         if (absorb_byte(c))
            emit_declaration();
      end
      if (c == CH_NUL || last) begin
         // an open value is flushed up to the current position
         if (!full && phase_now == PH_VALUE) begin
            val_len_q = span_len(text_pos, val_start_q);
            emit_declaration();
            phase_now = PH_PROP_BEGIN;
         end
         rec             = '0;
         rec.entry_count = decls_out;
         rec.done_res    = 1'b1;
         pending_declarations.push_back(rec);
         text_done = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------------------
   // random helpers
   // ---------------------------------------------------------------------------

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] name_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(33, 255)); while (b == CH_COLON || b == CH_SEMI);
      return b;
   endfunction

   function automatic logic [7:0] value_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == CH_SEMI);
      return b;
   endfunction

   function automatic logic [7:0] paren_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == CH_RPAREN);
      return b;
   endfunction

   // ---------------------------------------------------------------------------
   // req channel driver
   // ---------------------------------------------------------------------------

   // one transaction on req; the prediction is made at the accepting edge
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = sender_idle ? pick_pause() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      split_text_byte(b, last);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], 1'b0);
   endtask

   // whitespace is anything at or below 0x20
   task automatic send_blanks(input int n);
      repeat (n) send_byte($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(1, 32)), 1'b0);
   endtask

   // stray separators, blanks and arbitrary bytes
   task automatic send_noise();
      int         kind;
      logic [7:0] b;
      repeat ($urandom_range(1, 6)) begin
         kind = $urandom_range(0, 4);
         case (kind)
            0:       b = CH_SEMI;
            1:       b = CH_COLON;
            2:       b = CH_SPACE;
            default: b = 8'($urandom_range(1, 255));
         endcase
         send_byte(b, 1'b0);
      end
   endtask

   // a well-formed declaration with random content
   task automatic send_random_declaration();
      int kind;
      int sep;
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0)
         send_blanks($urandom_range(1, 3));
      repeat ($urandom_range(1, 8)) send_byte(name_byte(), 1'b0);
      sep = $urandom_range(0, 2);
      if (sep != 0)
         send_blanks($urandom_range(1, 2));
      if (sep != 1)
         send_byte(CH_COLON, 1'b0);
      if ($urandom_range(0, 2) == 0)
         send_blanks($urandom_range(1, 2));
      if (kind < 20) begin
         // url( ... ) keeps ';' inside the parentheses
         send_text("url(");
         repeat ($urandom_range(0, 6))
            send_byte(($urandom_range(0, 2) == 0) ? CH_SEMI : paren_byte(), 1'b0);
         send_byte(CH_RPAREN, 1'b0);
         repeat ($urandom_range(0, 3)) send_byte(value_byte(), 1'b0);
      end else if (kind < 30) begin
         // broken url prefix falls back to ordinary value
         send_byte(CH_U, 1'b0);
         if ($urandom_range(0, 1))
            send_byte(CH_R, 1'b0);
         if ($urandom_range(0, 1))
            send_byte(CH_L, 1'b0);
         repeat ($urandom_range(0, 4)) send_byte(value_byte(), 1'b0);
      end else if (kind < 33) begin
         repeat ($urandom_range(100, 300)) send_byte(value_byte(), 1'b0);
      end else begin
         repeat ($urandom_range(1, 10)) send_byte(value_byte(), 1'b0);
      end
      send_byte(CH_SEMI, 1'b0);
   endtask

   // ---------------------------------------------------------------------------
   // csr write channel
   // ---------------------------------------------------------------------------

   // let every expected record arrive, then give the pipe time for silent bytes
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (pending_declarations.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_entries(input logic [7:0] value);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      entry_limit = value;
   endtask

   // ---------------------------------------------------------------------------
   // rsp channel: checker and random back-pressure
   // ---------------------------------------------------------------------------

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   int stall_left = 0;

   always @(posedge clock) begin : rsp_side
      decl_record_type seen;
      decl_record_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.property_start  = rsp_tdata[15:0];
         seen.property_length = rsp_tdata[31:16];
         seen.value_start     = rsp_tdata[47:32];
         seen.value_length    = rsp_tdata[63:48];
         seen.entry_count     = rsp_tdata[71:64];
         seen.has_property    = rsp_tuser[0];
         seen.has_value       = rsp_tuser[1];
         seen.done_res        = rsp_tlast;
         if (pending_declarations.size() == 0) begin
            $error("unexpected rsp transaction, entry_count %0d done_res %0d",
                   seen.entry_count, seen.done_res);
            fail_count++;
         end else begin
            want = pending_declarations.pop_front();
            check_field("has_property", want.has_property, seen.has_property);
            check_field("property_start", want.property_start, seen.property_start);
            check_field("property_length", want.property_length, seen.property_length);
            check_field("has_value", want.has_value, seen.has_value);
            check_field("value_start", want.value_start, seen.value_start);
            check_field("value_length", want.value_length, seen.value_length);
            check_field("entry_count", want.entry_count, seen.entry_count);
            check_field("done_res", want.done_res, seen.done_res);
         end
      end
      // a long hold lets the block fill up and push back on req
      if (long_hold_request) begin
         long_hold_request = 1'b0;
         stall_left        = LONG_HOLD;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (receiver_idle && $urandom_range(0, 99) < 25) begin
         stall_left = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 2)
                                                  : $urandom_range(7, 39);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // blanks while waiting, stray ';' and ':', both ways to close a property,
   // url( with ';' inside, top byte value, ';' right after a property name,
   // broken url prefix
   task automatic test_directed_text();
      send_text("\001;:a b;x:url(;)\377;q;m:ur;");
   endtask

   // zero and one are below the count already out, then the limit is hit exactly
   task automatic test_record_limit();
      write_max_entries(8'd0);
      send_text("a:b;;");
      write_max_entries(8'd1);
      send_text("c:d;");
      write_max_entries(decls_out + 8'd2);
      send_text("e:f;g:h;i:j;");
   endtask

   // random text in several stretches, each with its own limit and idling
   task automatic test_random_text();
      int goal_total;
      int stretch_goal;
      int stretch_no;
      int next_limit;
      goal_total = bytes_processed + RANDOM_BYTES;
      stretch_no = 0;
      while (bytes_processed < goal_total && decls_out < ENTRY_CEILING) begin
         next_limit = decls_out + $urandom_range(8, 40);
         if (next_limit > ENTRY_CEILING)
            next_limit = ENTRY_CEILING;
         write_max_entries(8'(next_limit));
         // first stretch runs with no idling, the third one leans on the rsp side
         sender_idle   = !(stretch_no == 0 || stretch_no == 2);
         receiver_idle = (stretch_no != 0);
         if (stretch_no == 2)
            long_hold_request = 1'b1;
         stretch_goal = bytes_processed + 300;
         while (bytes_processed < stretch_goal && decls_out < entry_limit) begin
            if ($urandom_range(0, 99) < 85)
               send_random_declaration();
            else
               send_noise();
         end
         // bytes past the limit must be dropped silently
         if (decls_out >= entry_limit)
            send_noise();
         stretch_no++;
      end
   endtask

   // one long value of LONG_RUN bytes, back to back
   task automatic test_long_value();
      write_max_entries(8'hFF);
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      send_text(";p:");
      repeat (LONG_RUN) send_byte("v", 1'b0);
      send_byte(CH_SEMI, 1'b0);
      send_text("z;k:w");
   endtask

   // last byte inside an open value: value flushed, then the count record
   task automatic test_end_of_text();
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      send_byte("y", 1'b1);
   endtask

   // once the count record is out nothing else may come back
   task automatic test_quiet_after_done();
      send_byte(CH_NUL, 1'b0);
      send_byte(CH_NUL, 1'b1);
      repeat (20) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_text();
      test_record_limit();
      test_random_text();
      test_long_value();
      test_end_of_text();
      test_quiet_after_done();

      req_tvalid <= 1'b0;
      while (pending_declarations.size() != 0) @(posedge clock);
      repeat (2 * DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
sv/cds_pkg.sv
sv/cds_front.sv
sv/cds_queue.sv
sv/cds_back.sv
sv/cds_out.sv
sv/css_declaration_splitter.sv
sim/css_declaration_splitter_tb.sv
